/* rtl/core/gerq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gerq_pkg;

  // grid step register, unsigned Q4.16
  localparam int GRID_STEP_W = 20;
  localparam logic [GRID_STEP_W-1:0] GRID_STEP_RESET = 20'd65536;

  // default sizes for the top level
  localparam int MAX_INTERVALS_DEF = 1024;
  localparam int SAMPLE_BITS_DEF   = 24;

  // result fields
  localparam int ENERGY_W = 32;
  localparam int STATUS_W = 3;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_FEW  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_MANY = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SAT      = 3'd4;

  localparam logic [ENERGY_W-1:0] ENERGY_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [ENERGY_W-1:0] ENERGY_NEG_MAX = 32'h8000_0000;

  // fixed-point alignment of kinetic term and of the norm
  localparam int KIN_SHIFT = 66;
  localparam int DEN_SHIFT = 19;

  // grid point position for the stencil
  localparam logic [1:0] POS_LEFT  = 2'd0;
  localparam logic [1:0] POS_MID   = 2'd1;
  localparam logic [1:0] POS_RIGHT = 2'd2;

  // shared unit operations
  localparam logic OP_MAC = 1'b0;
  localparam logic OP_DIV = 1'b1;

  typedef struct packed {
    logic start;
    logic mode;
    logic sub;
  } alu_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/gerq_alu.sv */
`timescale 1ns / 1ps
`default_nettype none

// Shared wide unit: shift-add multiply-accumulate (acc +/- mcand * mplier)
// and restoring divide (mplier / mcand, quotient left in mplier).
module gerq_alu #(
  parameter int UW = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire gerq_pkg::alu_ctl_t ctl,
  input  wire logic [UW-1:0]     acc_in,
  input  wire logic [UW-1:0]     mcand_in,
  input  wire logic [UW-1:0]     mplier_in,
  output logic                   busy,
  output logic [UW-1:0]          acc,
  output logic [UW-1:0]          quo
);
  import gerq_pkg::*;

  localparam int DCW = $clog2(UW + 1);

  logic [UW-1:0]  acc_r, acc_nxt;
  logic [UW-1:0]  mcand_r, mcand_nxt;
  logic [UW-1:0]  mplier_r, mplier_nxt;
  logic           mode_r, mode_nxt;
  logic           sub_r, sub_nxt;
  logic           busy_r, busy_nxt;
  logic [DCW-1:0] cnt_r, cnt_nxt;

  logic [UW-1:0]  div_a;
  logic [UW-1:0]  op_a;
  logic           op_sub;
  logic [UW:0]    sum;

  // one adder serves both operations
  always_comb begin
    div_a  = {acc_r[UW-2:0], mplier_r[UW-1]};
    op_a   = (mode_r == OP_DIV) ? div_a : acc_r;
    op_sub = (mode_r == OP_DIV) ? 1'b1 : sub_r;
    sum    = {1'b0, op_a} + ({1'b0, mcand_r} ^ {(UW+1){op_sub}}) + (UW+1)'(op_sub);
  end

  always_comb begin
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    mode_nxt   = mode_r;
    sub_nxt    = sub_r;
    busy_nxt   = busy_r;
    cnt_nxt    = cnt_r;
    if (ctl.start) begin
      acc_nxt    = acc_in;
      mcand_nxt  = mcand_in;
      mplier_nxt = mplier_in;
      mode_nxt   = ctl.mode;
      sub_nxt    = ctl.sub;
      busy_nxt   = 1'b1;
      cnt_nxt    = DCW'(UW);
    end else if (busy_r) begin
      if (mode_r == OP_DIV) begin
        if (cnt_r == '0) begin
          busy_nxt = 1'b0;
        end else begin
          // keep the difference when no borrow
          acc_nxt    = sum[UW] ? div_a : sum[UW-1:0];
          mplier_nxt = {mplier_r[UW-2:0], ~sum[UW]};
          cnt_nxt    = cnt_r - DCW'(1);
        end
      end else begin
        if (mplier_r == '0) begin
          busy_nxt = 1'b0;
        end else begin
          if (mplier_r[0]) begin
            acc_nxt = sum[UW-1:0];
          end
          mcand_nxt  = {mcand_r[UW-2:0], 1'b0};
          mplier_nxt = {1'b0, mplier_r[UW-1:1]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    mode_r   <= mode_nxt;
    sub_r    <= sub_nxt;
    cnt_r    <= cnt_nxt;
  end

  assign busy = busy_r;
  assign acc  = acc_r;
  assign quo  = mplier_r;

endmodule

`default_nettype wire

/* rtl/core/gerq_stencil.sv */
`timescale 1ns / 1ps
`default_nettype none

// Second-difference stencil over a window of up to four samples; gives the
// magnitude and sign of the sample at the grid point and of the stencil sum.
module gerq_stencil #(
  parameter int SW = 24
) (
  input  wire logic [1:0]           pos,
  input  wire logic signed [SW-1:0] w0,
  input  wire logic signed [SW-1:0] w1,
  input  wire logic signed [SW-1:0] w2,
  input  wire logic signed [SW-1:0] w3,
  output logic [SW-1:0]             s_mag,
  output logic                      s_neg,
  output logic [SW+2:0]             c_mag,
  output logic                      c_neg
);
  import gerq_pkg::*;

  localparam int CW = SW + 4;

  logic signed [CW-1:0] e0, e1, e2, e3;
  logic signed [CW-1:0] c;
  logic signed [SW-1:0] s;
  logic signed [CW-1:0] c_abs;
  logic signed [SW:0]   s_abs;

  always_comb begin
    e0 = CW'(w0);
    e1 = CW'(w1);
    e2 = CW'(w2);
    e3 = CW'(w3);
    case (pos)
      POS_LEFT: begin
        c = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
        s = w0;
      end
      POS_RIGHT: begin
        c = (e3 <<< 1) - ((e2 <<< 2) + e2) + (e1 <<< 2) - e0;
        s = w3;
      end
      default: begin
        c = e0 + e2 - (e1 <<< 1);
        s = w1;
      end
    endcase
    s_neg = s[SW-1];
    s_abs = s_neg ? -(SW+1)'(s) : (SW+1)'(s);
    s_mag = s_abs[SW-1:0];
    c_neg = c[CW-1];
    c_abs = c_neg ? -c : c;
    c_mag = c_abs[SW+2:0];
  end

endmodule

`default_nettype wire

/* rtl/core/grid_energy_rayleigh_quotient.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    in_sample (signed Q8.16), in_last
// out_      output     out_valid / out_ready  out_energy (signed Q16.16), out_status
// cfg_      input      cfg_valid / cfg_ready  cfg_grid_step (unsigned Q4.16)
//
// Samples load one per cycle into the sample memory; the request flagged
// last starts the evaluation, and in_ready stays low until the result is
// handed to the output register. The evaluation walks the grid once and
// runs every product through one shift-add unit: each grid point reads its
// memory window and then multiplies, and a multiply ends once its remaining
// multiplier bits are zero, so small samples finish sooner; the final
// scaling and the bit-serial divide (one quotient bit per cycle over the
// unit width) follow.
// Reset is synchronous, active low, and clears control only.
// A waiting result does not block loading of the next grid.
module grid_energy_rayleigh_quotient #(
  parameter int MAX_INTERVALS = gerq_pkg::MAX_INTERVALS_DEF,
  parameter int SAMPLE_BITS   = gerq_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0]       in_sample,
  input  wire logic                                in_last,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [gerq_pkg::ENERGY_W-1:0]     out_energy,
  output logic [gerq_pkg::STATUS_W-1:0]            out_status,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [gerq_pkg::GRID_STEP_W-1:0]    cfg_grid_step
);
  import gerq_pkg::*;

  // Sizes of the memory and of every running sum
  localparam int SW    = SAMPLE_BITS;
  localparam int DEPTH = MAX_INTERVALS + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);
  localparam int KMW   = $clog2(MAX_INTERVALS + 1);
  localparam int CMW   = SW + 3;
  localparam int SUMX  = $clog2(2 * DEPTH) + 1;
  localparam int KSW   = KMW + SW;
  localparam int SSW   = 2 * SW + SUMX;
  localparam int SAW   = 2 * KSW + SUMX;
  localparam int SBW   = 2 * SW + 4 + SUMX;
  localparam int G2W   = 2 * GRID_STEP_W;
  localparam int G4W   = 4 * GRID_STEP_W;
  localparam int DENW  = G2W + SSW;
  localparam int NA    = G4W + SAW;
  localparam int NB    = SBW + KIN_SHIFT;
  localparam int NUMW  = ((NA > NB) ? NA : NB) + 2;
  localparam int DVW   = DENW + DEN_SHIFT + 1;
  localparam int UW    = ((NUMW > DVW) ? NUMW : DVW) + 2;

  // Sequencer states
  localparam logic [4:0] S_LOAD  = 5'd0;
  localparam logic [4:0] S_CHECK = 5'd1;
  localparam logic [4:0] S_RD    = 5'd2;
  localparam logic [4:0] S_RDW   = 5'd3;
  localparam logic [4:0] S_KS    = 5'd4;
  localparam logic [4:0] S_SA    = 5'd5;
  localparam logic [4:0] S_SS    = 5'd6;
  localparam logic [4:0] S_SB    = 5'd7;
  localparam logic [4:0] S_NEXT  = 5'd8;
  localparam logic [4:0] S_G2    = 5'd9;
  localparam logic [4:0] S_DEN   = 5'd10;
  localparam logic [4:0] S_G4    = 5'd11;
  localparam logic [4:0] S_NUM   = 5'd12;
  localparam logic [4:0] S_SUBB  = 5'd13;
  localparam logic [4:0] S_NEG   = 5'd14;
  localparam logic [4:0] S_N2    = 5'd15;
  localparam logic [4:0] S_DIV   = 5'd16;
  localparam logic [4:0] S_FIN   = 5'd17;
  localparam logic [4:0] S_OUT   = 5'd18;

  // Sample memory
  logic signed [SW-1:0] mem [DEPTH];
  logic signed [SW-1:0] rdata_r;
  logic [AW-1:0]        raddr;
  logic                 mem_we;

  // Control state
  logic [4:0]             state_r, state_nxt;
  logic [CNTW-1:0]        cnt_r, cnt_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [GRID_STEP_W-1:0] grid_step_r, grid_step_nxt;
  logic [AW-1:0]          idx_r, idx_nxt;
  logic [AW-1:0]          nx_r, nx_nxt;
  logic [1:0]             rd_j_r, rd_j_nxt;
  logic                   issued_r, issued_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // Datapath registers
  logic signed [SW-1:0]   win_r [4];
  logic signed [SW-1:0]   win_nxt [4];
  logic [KSW-1:0]         ks_r, ks_nxt;
  logic [SSW-1:0]         ss_r, ss_nxt;
  logic [SAW-1:0]         sa_r, sa_nxt;
  logic signed [SBW-1:0]  sb_r, sb_nxt;
  logic [G2W-1:0]         g2_r, g2_nxt;
  logic [DENW-1:0]        den_r, den_nxt;
  logic [G4W-1:0]         g4_r, g4_nxt;
  logic [UW-1:0]          tmp_r, tmp_nxt;
  logic                   neg_r, neg_nxt;
  logic [STATUS_W-1:0]    status_r, status_nxt;
  logic [ENERGY_W-1:0]    energy_r, energy_nxt;
  logic [ENERGY_W-1:0]    out_energy_r, out_energy_nxt;
  logic [STATUS_W-1:0]    out_status_r, out_status_nxt;

  // Grid point decode
  logic [1:0]     pos;
  logic [AW-1:0]  base;
  logic [1:0]     last_j;
  logic [AW:0]    two_i;
  logic [AW:0]    k_abs;
  logic [KMW-1:0] k_mag;
  logic           wsh;
  logic [SW-1:0]  s_mag;
  logic           s_neg;
  logic [CMW-1:0] c_mag;
  logic           c_neg;
  logic [CNTW-1:0] nx_full;

  // Shared unit hookup
  alu_ctl_t       ctl;
  logic           is_op;
  logic           op_done;
  logic [UW-1:0]  op_acc, op_mcand, op_mplier;
  logic           op_mode, op_sub;
  logic           alu_busy;
  logic [UW-1:0]  alu_acc, alu_quo;

  // Final rounding and clamp
  logic           q_hi;
  logic [ENERGY_W-1:0] q_lo;
  logic [ENERGY_W-1:0] q_lim;
  logic           q_sat;

  logic in_acc;

  assign in_ready  = (state_r == S_LOAD);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_energy = out_energy_r;
  assign out_status = out_status_r;
  assign in_acc    = in_valid && in_ready;
  assign mem_we    = in_acc && (cnt_r < CNTW'(DEPTH));
  assign nx_full   = cnt_r - CNTW'(1);

  // Where the current grid point sits decides stencil and read window
  always_comb begin
    if (idx_r == '0) begin
      pos    = POS_LEFT;
      base   = '0;
      last_j = 2'd3;
    end else if (idx_r == nx_r) begin
      pos    = POS_RIGHT;
      base   = nx_r - AW'(3);
      last_j = 2'd3;
    end else begin
      pos    = POS_MID;
      base   = idx_r - AW'(1);
      last_j = 2'd2;
    end
    raddr = base + AW'(rd_j_r);
    // trapezoid weight: interior points count twice
    wsh   = (pos == POS_MID);
    // |2i - Nx|
    two_i = {idx_r, 1'b0};
    k_abs = (two_i >= {1'b0, nx_r}) ? (two_i - {1'b0, nx_r}) : ({1'b0, nx_r} - two_i);
    k_mag = k_abs[KMW-1:0];
  end

  gerq_stencil #(
    .SW (SW)
  ) u_stencil (
    .pos   (pos),
    .w0    (win_r[0]),
    .w1    (win_r[1]),
    .w2    (win_r[2]),
    .w3    (win_r[3]),
    .s_mag (s_mag),
    .s_neg (s_neg),
    .c_mag (c_mag),
    .c_neg (c_neg)
  );

  // Operand selection for the shared unit, one operation per state
  always_comb begin
    is_op     = 1'b1;
    op_acc    = '0;
    op_mcand  = '0;
    op_mplier = '0;
    op_mode   = OP_MAC;
    op_sub    = 1'b0;
    case (state_r)
      S_KS: begin
        op_mcand  = UW'(s_mag);
        op_mplier = UW'(k_mag);
      end
      S_SA: begin
        op_acc    = UW'(sa_r);
        op_mcand  = UW'(ks_r) << wsh;
        op_mplier = UW'(ks_r);
      end
      S_SS: begin
        op_acc    = UW'(ss_r);
        op_mcand  = UW'(s_mag) << wsh;
        op_mplier = UW'(s_mag);
      end
      S_SB: begin
        op_acc    = UW'(sb_r);
        op_mcand  = UW'(s_mag) << wsh;
        op_mplier = UW'(c_mag);
        op_sub    = s_neg ^ c_neg;
      end
      S_G2: begin
        op_mcand  = UW'(grid_step_r);
        op_mplier = UW'(grid_step_r);
      end
      S_DEN: begin
        op_mcand  = UW'(ss_r);
        op_mplier = UW'(g2_r);
      end
      S_G4: begin
        op_mcand  = UW'(g2_r);
        op_mplier = UW'(g2_r);
      end
      S_NUM: begin
        op_mcand  = UW'(sa_r);
        op_mplier = UW'(g4_r);
      end
      S_SUBB: begin
        // subtract the kinetic term, aligned by 2^66
        op_acc    = tmp_r;
        op_mcand  = UW'(sb_r) << KIN_SHIFT;
        op_mplier = UW'(1);
        op_sub    = 1'b1;
      end
      S_NEG: begin
        // take the magnitude of the numerator
        op_mcand  = tmp_r;
        op_mplier = UW'(1);
        op_sub    = tmp_r[UW-1];
      end
      S_N2: begin
        // 2|num| + den, so the divide rounds half away from zero
        op_acc    = UW'(den_r) << DEN_SHIFT;
        op_mcand  = {tmp_r[UW-2:0], 1'b0};
        op_mplier = UW'(1);
      end
      S_DIV: begin
        op_mode   = OP_DIV;
        op_mcand  = UW'(den_r) << (DEN_SHIFT + 1);
        op_mplier = tmp_r;
      end
      default: begin
        is_op = 1'b0;
      end
    endcase
    ctl.start = is_op && !issued_r;
    ctl.mode  = op_mode;
    ctl.sub   = op_sub;
    op_done   = is_op && issued_r && !alu_busy;
  end

  gerq_alu #(
    .UW (UW)
  ) u_alu (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .acc_in    (op_acc),
    .mcand_in  (op_mcand),
    .mplier_in (op_mplier),
    .busy      (alu_busy),
    .acc       (alu_acc),
    .quo       (alu_quo)
  );

  // Clamp the rounded magnitude to the int32 range of its sign
  always_comb begin
    q_hi  = |tmp_r[UW-1:ENERGY_W];
    q_lo  = tmp_r[ENERGY_W-1:0];
    q_lim = neg_r ? ENERGY_NEG_MAX : ENERGY_POS_MAX;
    q_sat = q_hi || (q_lo > q_lim);
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    ovf_nxt        = ovf_r;
    grid_step_nxt  = grid_step_r;
    idx_nxt        = idx_r;
    nx_nxt         = nx_r;
    rd_j_nxt       = rd_j_r;
    issued_nxt     = issued_r;
    out_valid_nxt  = out_valid_r;
    win_nxt        = win_r;
    ks_nxt         = ks_r;
    ss_nxt         = ss_r;
    sa_nxt         = sa_r;
    sb_nxt         = sb_r;
    g2_nxt         = g2_r;
    den_nxt        = den_r;
    g4_nxt         = g4_r;
    tmp_nxt        = tmp_r;
    neg_nxt        = neg_r;
    status_nxt     = status_r;
    energy_nxt     = energy_r;
    out_energy_nxt = out_energy_r;
    out_status_nxt = out_status_r;

    if (cfg_valid) begin
      grid_step_nxt = cfg_grid_step;
    end
    // drop the result once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctl.start) begin
      issued_nxt = 1'b1;
    end
    if (op_done) begin
      issued_nxt = 1'b0;
    end

    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (cnt_r < CNTW'(DEPTH)) begin
            cnt_nxt = cnt_r + CNTW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        energy_nxt = '0;
        if (ovf_r) begin
          status_nxt = ST_TOO_MANY;
          state_nxt  = S_OUT;
        end else if (cnt_r < CNTW'(4)) begin
          status_nxt = ST_TOO_FEW;
          state_nxt  = S_OUT;
        end else begin
          nx_nxt    = nx_full[AW-1:0];
          idx_nxt   = '0;
          rd_j_nxt  = '0;
          ss_nxt    = '0;
          sa_nxt    = '0;
          sb_nxt    = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_RDW;
      end
      S_RDW: begin
        win_nxt[rd_j_r] = rdata_r;
        if (rd_j_r == last_j) begin
          state_nxt = S_KS;
        end else begin
          rd_j_nxt  = rd_j_r + 2'd1;
          state_nxt = S_RD;
        end
      end
      S_KS: begin
        if (op_done) begin
          ks_nxt    = alu_acc[KSW-1:0];
          state_nxt = S_SA;
        end
      end
      S_SA: begin
        if (op_done) begin
          sa_nxt    = alu_acc[SAW-1:0];
          state_nxt = S_SS;
        end
      end
      S_SS: begin
        if (op_done) begin
          ss_nxt    = alu_acc[SSW-1:0];
          state_nxt = S_SB;
        end
      end
      S_SB: begin
        if (op_done) begin
          sb_nxt    = alu_acc[SBW-1:0];
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (idx_r == nx_r) begin
          state_nxt = S_G2;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          rd_j_nxt  = '0;
          state_nxt = S_RD;
        end
      end
      S_G2: begin
        if (op_done) begin
          g2_nxt    = alu_acc[G2W-1:0];
          state_nxt = S_DEN;
        end
      end
      S_DEN: begin
        if (op_done) begin
          den_nxt = alu_acc[DENW-1:0];
          if (alu_acc[DENW-1:0] == '0) begin
            status_nxt = ST_ZERO;
            energy_nxt = '0;
            state_nxt  = S_OUT;
          end else begin
            state_nxt = S_G4;
          end
        end
      end
      S_G4: begin
        if (op_done) begin
          g4_nxt    = alu_acc[G4W-1:0];
          state_nxt = S_NUM;
        end
      end
      S_NUM: begin
        if (op_done) begin
          tmp_nxt   = alu_acc;
          state_nxt = S_SUBB;
        end
      end
      S_SUBB: begin
        if (op_done) begin
          tmp_nxt   = alu_acc;
          state_nxt = S_NEG;
        end
      end
      S_NEG: begin
        if (op_done) begin
          neg_nxt   = tmp_r[UW-1];
          tmp_nxt   = alu_acc;
          state_nxt = S_N2;
        end
      end
      S_N2: begin
        if (op_done) begin
          tmp_nxt   = alu_acc;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (op_done) begin
          tmp_nxt   = alu_quo;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (q_sat) begin
          energy_nxt = q_lim;
          status_nxt = ST_SAT;
        end else begin
          energy_nxt = neg_r ? (ENERGY_W'(0) - q_lo) : q_lo;
          status_nxt = ST_OK;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free, then start the next grid
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_energy_nxt = energy_r;
          out_status_nxt = status_r;
          cnt_nxt        = '0;
          ovf_nxt        = 1'b0;
          state_nxt      = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // Sample memory: write while loading, registered read while walking
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[AW-1:0]] <= in_sample;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      grid_step_r <= GRID_STEP_RESET;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      grid_step_r <= grid_step_nxt;
      issued_r    <= issued_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    nx_r         <= nx_nxt;
    rd_j_r       <= rd_j_nxt;
    win_r        <= win_nxt;
    ks_r         <= ks_nxt;
    ss_r         <= ss_nxt;
    sa_r         <= sa_nxt;
    sb_r         <= sb_nxt;
    g2_r         <= g2_nxt;
    den_r        <= den_nxt;
    g4_r         <= g4_nxt;
    tmp_r        <= tmp_nxt;
    neg_r        <= neg_nxt;
    status_r     <= status_nxt;
    energy_r     <= energy_nxt;
    out_energy_r <= out_energy_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

`default_nettype wire
